// ===== sv/crlm_pkg.sv =====
// Package for the chunk RMS level meter: widths, limits and shared types.
// Depends on nothing; every other file of the block imports it.
package crlm_pkg;

  localparam int COUNT_BITS = 16;                   // width of the per-chunk sample counter
  localparam int SAMPLE_W   = 16;
  localparam int MAG_W      = 16;                   // |sample| is at most 2^15
  localparam int PROD_W     = 2 * MAG_W;            // serial multiplier register width
  localparam int SQ_W       = 31;                   // a square is at most 2^30
  localparam int SUM_W      = SQ_W + COUNT_BITS;    // exact sum of squares
  localparam int ROOT_W     = 16;                   // root is at most 2^15
  localparam int RAD_W      = 2 * ROOT_W;           // radicand padded to whole bit pairs
  localparam int CHUNK_W    = 32;

  localparam int SQ_CNT_W   = $clog2(MAG_W);
  localparam int DIV_CNT_W  = $clog2(SUM_W);
  localparam int RT_CNT_W   = $clog2(ROOT_W);

  localparam logic [COUNT_BITS-1:0] TALLY_MAX = '1;

  typedef logic [SUM_W-1:0]      sum_t;
  typedef logic [COUNT_BITS-1:0] tally_t;
  typedef logic [ROOT_W-1:0]     root_t;

endpackage

// ===== sv/crlm_in_if.sv =====
// Input channel of the level meter: one PCM sample and its end-of-chunk flag per beat.
// Depends on crlm_pkg for the sample width.
interface crlm_in_if import crlm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last_in_chunk;

  modport source (output valid, sample, last_in_chunk, input ready);
  modport sink   (input valid, sample, last_in_chunk, output ready);
endinterface

// ===== sv/crlm_out_if.sv =====
// Result channel of the level meter: one beat per finished chunk.
// Depends on crlm_pkg for the field widths.
interface crlm_out_if import crlm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ROOT_W-1:0]  rms_level;
  logic [CHUNK_W-1:0] chunks_done;
  logic               chunk_overflow;

  modport source (output valid, rms_level, chunks_done, chunk_overflow, input ready);
  modport sink   (input valid, rms_level, chunks_done, chunk_overflow, output ready);
endinterface

// ===== sv/chunk_rms_level_meter_top.sv =====
// Chunk RMS level meter: sum of squares per chunk, then floor(sqrt(floor(sum / count))).
// A sample that does not end a chunk and is not dropped holds the input while the 16-step
// serial squarer works on it. A chunk-ending sample passes the squarer, the divider, the
// square root and the hand-over states before its result beat is offered; a closing sample
// dropped by the full counter skips the squarer. One sample is in work at a time.
// Reset clears the sum, counters, flag and result valid.
module chunk_rms_level_meter_top import crlm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  crlm_in_if.sink    in_i,
  crlm_out_if.source out_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SQR   = 3'd1;
  localparam logic [2:0] ST_DIVGO = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_SQRT  = 3'd4;
  localparam logic [2:0] ST_PUT   = 3'd5;

  logic [2:0]          state_q, state_d;
  sum_t                sum_q;
  tally_t              tally_q;
  logic [CHUNK_W-1:0]  chunk_q;
  logic                ovf_q, last_q;
  logic                out_valid_q;
  root_t               rms_q;
  logic [CHUNK_W-1:0]  done_cnt_q;
  logic                done_ovf_q;

  logic                accept, full, put;
  logic [MAG_W-1:0]    mag;
  logic                sq_start, sq_done, div_done, rt_done;
  logic [SQ_W-1:0]     square, quotient;
  root_t               root;

  assign accept   = in_i.valid && in_i.ready;
  assign full     = (tally_q == TALLY_MAX);
  assign mag      = in_i.sample[SAMPLE_W-1] ? MAG_W'(-in_i.sample) : MAG_W'(in_i.sample);
  assign sq_start = accept && !full;
  assign put      = (state_q == ST_PUT) && (!out_valid_q || out_o.ready);

  crlm_square u_square (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (sq_start),
    .mag_i    (mag),
    .done_o   (sq_done),
    .square_o (square)
  );

  crlm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == ST_DIVGO),
    .dividend_i (sum_q),
    .divisor_i  (tally_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  crlm_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_done),
    .radicand_i (quotient),
    .done_o     (rt_done),
    .root_o     (root)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!full) begin
            state_d = ST_SQR;
          end else if (in_i.last_in_chunk) begin
            state_d = ST_DIVGO;
          end
        end
      end
      ST_SQR: begin
        if (sq_done) begin
          state_d = last_q ? ST_DIVGO : ST_IDLE;
        end
      end
      ST_DIVGO: state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (rt_done) begin
          state_d = ST_PUT;
        end
      end
      ST_PUT: begin
        if (put) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      tally_q     <= '0;
      chunk_q     <= '0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        last_q <= in_i.last_in_chunk;
        // With the counter full the sample is dropped and only the flag records it.
        if (full) begin
          ovf_q <= 1'b1;
        end
      end
      if ((state_q == ST_SQR) && sq_done) begin
        sum_q   <= sum_q + SUM_W'(square);
        tally_q <= tally_q + 1'b1;
      end
      if (put) begin
        out_valid_q <= 1'b1;
        chunk_q     <= chunk_q + 1'b1;
        sum_q       <= '0;
        tally_q     <= '0;
        ovf_q       <= 1'b0;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (put) begin
      rms_q      <= root;
      done_cnt_q <= chunk_q + 1'b1;
      done_ovf_q <= ovf_q;
    end
  end

  assign in_i.ready           = (state_q == ST_IDLE);
  assign out_o.valid          = out_valid_q;
  assign out_o.rms_level      = rms_q;
  assign out_o.chunks_done    = done_cnt_q;
  assign out_o.chunk_overflow = done_ovf_q;

endmodule

// ===== sv/crlm_square.sv =====
// Bit-serial squarer: shift-and-add over the magnitude, one multiplier bit per cycle.
// Depends on crlm_pkg.
module crlm_square import crlm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [MAG_W-1:0] mag_i,
  output logic             done_o,
  output logic [SQ_W-1:0]  square_o
);

  logic                busy_q, done_q;
  logic [SQ_CNT_W-1:0] cnt_q;
  logic [PROD_W-1:0]   a_q, p_q;
  logic [MAG_W-1:0]    b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= SQ_CNT_W'(MAG_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= PROD_W'(mag_i);
      b_q <= mag_i;
      p_q <= '0;
    end else if (busy_q) begin
      if (b_q[0]) begin
        p_q <= p_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

  assign done_o   = done_q;
  assign square_o = p_q[SQ_W-1:0];

endmodule

// ===== sv/crlm_div.sv =====
// Restoring divider: one quotient bit per cycle of the sum of squares by the sample count.
// Depends on crlm_pkg.
module crlm_div import crlm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  sum_t            dividend_i,
  input  tally_t          divisor_i,
  output logic            done_o,
  output logic [SQ_W-1:0] quotient_o
);

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  tally_t               rem_q, den_q;
  sum_t                 dq_q;
  logic [COUNT_BITS:0]  shifted, diff;
  logic                 qbit;

  // The dividend shifts out of the top of dq_q while quotient bits enter at the bottom.
  assign shifted = {rem_q, dq_q[SUM_W-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign qbit    = !diff[COUNT_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(SUM_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dq_q  <= dividend_i;
      // An empty chunk cannot occur; a zero count is treated as one all the same.
      den_q <= (divisor_i == '0) ? tally_t'(1) : divisor_i;
    end else if (busy_q) begin
      rem_q <= qbit ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
      dq_q  <= {dq_q[SUM_W-2:0], qbit};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q[SQ_W-1:0];

endmodule

// ===== sv/crlm_sqrt.sv =====
// Digit-by-digit integer square root: one bit pair of the radicand per cycle.
// Depends on crlm_pkg.
module crlm_sqrt import crlm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [SQ_W-1:0] radicand_i,
  output logic            done_o,
  output root_t           root_o
);

  logic                busy_q, done_q;
  logic [RT_CNT_W-1:0] cnt_q;
  logic [RAD_W-1:0]    x_q;
  logic [ROOT_W:0]     rem_q;
  root_t               root_q;
  logic [ROOT_W+2:0]   partial, trial, diff;
  logic                fits;

  assign partial = {rem_q, x_q[RAD_W-1 -: 2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign diff    = partial - trial;
  assign fits    = (partial >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= RT_CNT_W'(ROOT_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= RAD_W'(radicand_i);
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q    <= x_q << 2;
      // The remainder never exceeds twice the root, so it fits one bit above the root.
      rem_q  <= fits ? diff[ROOT_W:0] : partial[ROOT_W:0];
      root_q <= {root_q[ROOT_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== sv/crlm_checker.sv =====
// Port-level checker for the level meter and the bind that attaches it to the top level.
// Depends on crlm_pkg and on chunk_rms_level_meter_top.
module crlm_checker import crlm_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               in_last_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [ROOT_W-1:0]  rms_level_i,
  input logic [CHUNK_W-1:0] chunks_done_i,
  input logic               chunk_overflow_i
);

  logic [CHUNK_W-1:0] prev_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_cnt_q <= '0;
    end else if (out_valid_i && out_ready_i) begin
      prev_cnt_q <= chunks_done_i;
    end
  end

  // A held result beat keeps its payload until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(rms_level_i)
      && $stable(chunks_done_i) && $stable(chunk_overflow_i))
    else $error("result beat changed while stalled");

  a_rms_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> rms_level_i <= ROOT_W'(32768))
    else $error("rms level above full scale");

  // Every result carries the chunk number one past the previous result.
  a_chunk_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> chunks_done_i == prev_cnt_q + 1'b1)
    else $error("chunk count skipped or repeated");

  // The closing sample of a chunk starts the serial arithmetic, so input stalls next.
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("input taken while a chunk result is being computed");

endmodule

bind chunk_rms_level_meter_top crlm_checker u_crlm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .in_last_i        (in_i.last_in_chunk),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .rms_level_i      (out_o.rms_level),
  .chunks_done_i    (out_o.chunks_done),
  .chunk_overflow_i (out_o.chunk_overflow)
);

// ===== sim/tb_chunk_rms_level_meter_top.sv =====
// Self-checking testbench for the chunk RMS level meter: directed, random, back-pressure and
// drain tests, each result beat checked against an in-bench predictor.
// Depends on crlm_pkg, crlm_in_if, crlm_out_if and chunk_rms_level_meter_top.
`timescale 1ns / 1ps

module tb_chunk_rms_level_meter_top;
  import crlm_pkg::*;

  localparam int      DRAIN_CYCLES    = 200;
  localparam int      HOLD_OFF_CYCLES = 2000;
  localparam longint  CYCLE_LIMIT     = 6_000_000;

  typedef struct packed {
    root_t              rms;
    logic [CHUNK_W-1:0] chunks;
    logic               ovf;
  } level_beat_t;

  logic clk;
  logic rst_n;

  crlm_in_if  in_ch ();
  crlm_out_if out_ch ();

  chunk_rms_level_meter_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Predictor state for the chunk in progress.
  sum_t               meter_sum;
  tally_t             meter_count;
  logic [CHUNK_W-1:0] meter_chunks;
  logic               meter_ovf;

  level_beat_t pending_levels[$];
  int          fail_count;
  longint      cycle_count;
  bit          send_idle_on;
  bit          recv_idle_on;
  bit          hold_off_req;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Floor of the square root of the floored mean, by trial of each result bit from the top.
  function automatic root_t rms_of(sum_t sum, tally_t n);
    longint unsigned quot;
    longint unsigned cand;
    longint unsigned root;
    quot = sum / ((n == '0) ? 1 : n);
    root = 0;
    for (int i = ROOT_W - 1; i >= 0; i--) begin
      cand = root | (64'd1 << i);
      if (cand * cand <= quot) root = cand;
    end
    return root_t'(root);
  endfunction

  function automatic void absorb_sample(logic signed [SAMPLE_W-1:0] s, logic eoc);
    logic [SAMPLE_W-1:0] raw;
    sum_t                mag;
    level_beat_t         beat;
    raw = s;
    mag = raw[SAMPLE_W-1] ? sum_t'(17'h10000 - {1'b0, raw}) : sum_t'(raw);
    if (meter_count != TALLY_MAX) begin
      meter_sum   = meter_sum + mag * mag;
      meter_count = meter_count + 1'b1;
    end else begin
      meter_ovf = 1'b1;
    end
    if (eoc) begin
      meter_chunks = meter_chunks + 1'b1;
      beat.rms     = rms_of(meter_sum, meter_count);
      beat.chunks  = meter_chunks;
      beat.ovf     = meter_ovf;
      pending_levels.push_back(beat);
      meter_sum    = '0;
      meter_count  = '0;
      meter_ovf    = 1'b0;
    end
  endfunction

  // Mostly no idling, some short gaps and now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 200);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] next_sample();
    int r;
    logic signed [SAMPLE_W-1:0] s;
    r = $urandom_range(0, 9);
    unique case (r)
      0: s = 16'sh7FFF;
      1: s = -16'sh8000;
      2: begin
        s = SAMPLE_W'($urandom_range(0, 15));
        if ($urandom_range(0, 1) == 1) s = -s;
      end
      3: s = '0;
      default: s = SAMPLE_W'($urandom);
    endcase
    return s;
  endfunction

  // Called at a rising edge; leaves valid high unless a gap follows the beat.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic eoc);
    int gap;
    in_ch.valid         <= 1'b1;
    in_ch.sample        <= s;
    in_ch.last_in_chunk <= eoc;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    absorb_sample(s, eoc);
    gap = send_idle_on ? idle_len() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_chunk(input int len);
    for (int i = 0; i < len; i++) send_sample(next_sample(), i == len - 1);
  endtask

  task automatic test_directed();
    send_sample(16'sd0, 1'b1);
    send_sample(16'sh7FFF, 1'b1);
    send_sample(-16'sh8000, 1'b1);
    send_sample(-16'sd1, 1'b1);
    send_sample(16'sd1, 1'b1);
    // A chunk of nothing but the most negative sample reaches the top of the range.
    send_sample(-16'sh8000, 1'b0);
    send_sample(-16'sh8000, 1'b0);
    send_sample(-16'sh8000, 1'b1);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(-16'sh8000, 1'b1);
    // Both floors matter here: 5 / 2 truncates to 2, whose root truncates to 1.
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd2, 1'b1);
    send_sample(16'sh5555, 1'b0);
    send_sample(-16'sh5556, 1'b0);
    send_sample(16'sh2AAA, 1'b0);
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd3, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b1);
  endtask

  task automatic test_random_chunks(input int target);
    int sent;
    int len;
    int r;
    sent = 0;
    while (sent < target) begin
      // The first stretch runs with neither side idling.
      send_idle_on = (sent >= 200);
      recv_idle_on = (sent >= 200);
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(1, 8);
      else if (r < 95) len = $urandom_range(9, 40);
      else len = $urandom_range(41, 200);
      send_chunk(len);
      sent += len;
    end
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
  endtask

  // The receiver stops for a long stretch while short chunks keep coming, so the
  // block holds a finished result and has to stall its input.
  task automatic test_hold_off();
    send_idle_on = 1'b0;
    hold_off_req = 1'b1;
    for (int i = 0; i < 60; i++) send_chunk($urandom_range(1, 2));
    send_idle_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    send_chunk($urandom_range(1, 6));
    in_ch.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    send_chunk($urandom_range(1, 6));
    send_chunk(1);
  endtask

  // Result side: ready pattern, with the long hold-off counted here.
  initial begin
    int idle_left;
    idle_left    = 0;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        idle_left    = HOLD_OFF_CYCLES;
      end
      if (idle_left > 0) begin
        out_ch.ready <= 1'b0;
        idle_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (recv_idle_on) idle_left = idle_len();
      end
    end
  end

  always @(posedge clk) begin
    level_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_levels.size() == 0) begin
        $error("result beat with no finished chunk pending");
        fail_count++;
      end else begin
        want = pending_levels.pop_front();
        if (out_ch.rms_level !== want.rms) begin
          $error("rms_level: expected %0d, got %0d", want.rms, out_ch.rms_level);
          fail_count++;
        end
        if (out_ch.chunks_done !== want.chunks) begin
          $error("chunks_done: expected %0d, got %0d", want.chunks, out_ch.chunks_done);
          fail_count++;
        end
        if (out_ch.chunk_overflow !== want.ovf) begin
          $error("chunk_overflow: expected %0d, got %0d", want.ovf, out_ch.chunk_overflow);
          fail_count++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("chunk_rms_level_meter_top regression: fail");
    $finish;
  end

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.sample        = '0;
    in_ch.last_in_chunk = 1'b0;
    meter_sum           = '0;
    meter_count         = '0;
    meter_chunks        = '0;
    meter_ovf           = 1'b0;
    fail_count          = 0;
    send_idle_on        = 1'b1;
    recv_idle_on        = 1'b1;
    hold_off_req        = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_chunks(1000);
    test_hold_off();
    test_drain_pause();

    in_ch.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("chunk_rms_level_meter_top regression: pass");
    end else begin
      $display("chunk_rms_level_meter_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/crlm_pkg.sv
sv/crlm_in_if.sv
sv/crlm_out_if.sv
sv/crlm_square.sv
sv/crlm_div.sv
sv/crlm_sqrt.sv
sv/chunk_rms_level_meter_top.sv
sv/crlm_checker.sv
sim/tb_chunk_rms_level_meter_top.sv
